// ----- hdl/linear_system_3x3_solver_top_defines.svh -----
// assertion macros for the 3x3 linear system solver
// used by linear_system_3x3_solver_top, needs i_clk and i_rst_n in scope
`ifndef LINEAR_SYSTEM_3X3_SOLVER_TOP_DEFINES_SVH
`define LINEAR_SYSTEM_3X3_SOLVER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LSS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lss_pkg.sv -----
// shared types and constants of the 3x3 linear system solver
// no dependencies
package lss_pkg;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int MW = 2 * VW + 1;
    localparam int PW = 3 * VW + 3;
    localparam int NW = PW + FB;
    localparam int THR_W = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [THR_W-1:0] THR_RESET = 32'd3;

    localparam logic [1:0] ST_SOLVED    = 2'd0;
    localparam logic [1:0] ST_SINGULAR  = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    typedef struct packed {
        logic signed [VW-1:0] row1_coef_x;
        logic signed [VW-1:0] row1_coef_y;
        logic signed [VW-1:0] row1_coef_z;
        logic signed [VW-1:0] row1_offset;
        logic signed [VW-1:0] row2_coef_x;
        logic signed [VW-1:0] row2_coef_y;
        logic signed [VW-1:0] row2_coef_z;
        logic signed [VW-1:0] row2_offset;
        logic signed [VW-1:0] row3_coef_x;
        logic signed [VW-1:0] row3_coef_y;
        logic signed [VW-1:0] row3_coef_z;
        logic signed [VW-1:0] row3_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] sol_x;
        logic signed [VW-1:0] sol_y;
        logic signed [VW-1:0] sol_z;
        logic [1:0]           status;
    } t_out_item;

    typedef struct packed {
        logic signed [PW-1:0] nx;
        logic signed [PW-1:0] ny;
        logic signed [PW-1:0] nz;
        logic [PW-1:0]        dmag;
        logic                 dneg;
        logic                 sing;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/lss_front.sv -----
// front pipeline: minors, determinant, cofactor sums and singular check
// depends on lss_pkg
module lss_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  lss_pkg::t_in_item           i_in_data,
    output logic                        o_in_stall,
    input  logic [lss_pkg::THR_W-1:0]   i_thr,
    input  logic                        i_q_full,
    output logic                        o_push,
    output lss_pkg::t_job               o_job
);
    localparam int VW = lss_pkg::VW;
    localparam int MW = lss_pkg::MW;
    localparam int PW = lss_pkg::PW;
    localparam int THR_W = lss_pkg::THR_W;

    // minor k = b[MI]*c[MJ] - b[MJ]*c[MI]; index 0 is the offset column
    localparam int MI [6] = '{1, 1, 2, 0, 0, 0};
    localparam int MJ [6] = '{2, 3, 3, 1, 2, 3};
    // term t: sign, a column and minor; sums are D, Nx, Ny, Nz in groups of three
    localparam int TA [12] = '{1, 2, 3, 0, 2, 3, 1, 3, 0, 1, 2, 0};
    localparam int TM [12] = '{2, 1, 0, 2, 5, 4, 5, 3, 1, 4, 3, 0};
    localparam bit TN [12] = '{0, 1, 0, 1, 0, 1, 1, 0, 0, 0, 1, 1};

    logic signed [VW-1:0]     w_a [4];
    logic signed [VW-1:0]     w_b [4];
    logic signed [VW-1:0]     w_c [4];
    logic                     w_adv;
    logic [5:0]               r_v;
    logic signed [2*VW-1:0]   r_p1 [6];
    logic signed [2*VW-1:0]   r_p2 [6];
    logic signed [VW-1:0]     r_a1 [4];
    logic signed [MW-1:0]     r_m [6];
    logic signed [VW:0]       r_ta [12];
    logic signed [2*VW+1:0]   r_plo [12];
    logic signed [2*VW+1:0]   r_phi [12];
    logic signed [PW-1:0]     r_t [12];
    logic signed [PW-1:0]     r_s [4];
    logic signed [PW-1:0]     w_thr;
    logic signed [PW-1:0]     w_nthr;
    lss_pkg::t_job            r_job;

    always_comb begin
        w_a[0] = i_in_data.row1_offset;
        w_a[1] = i_in_data.row1_coef_x;
        w_a[2] = i_in_data.row1_coef_y;
        w_a[3] = i_in_data.row1_coef_z;
        w_b[0] = i_in_data.row2_offset;
        w_b[1] = i_in_data.row2_coef_x;
        w_b[2] = i_in_data.row2_coef_y;
        w_b[3] = i_in_data.row2_coef_z;
        w_c[0] = i_in_data.row3_offset;
        w_c[1] = i_in_data.row3_coef_x;
        w_c[2] = i_in_data.row3_coef_y;
        w_c[3] = i_in_data.row3_coef_z;
    end

    assign w_adv      = !(r_v[5] && i_q_full);
    assign o_in_stall = !w_adv;
    assign o_push     = r_v[5] && !i_q_full;
    assign o_job      = r_job;

    assign w_thr  = $signed({{(PW-THR_W){1'b0}}, i_thr});
    assign w_nthr = -w_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[4:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // 2x2 products of rows two and three
            for (int k = 0; k < 6; k++) begin
                r_p1[k] <= w_b[MI[k]] * w_c[MJ[k]];
                r_p2[k] <= w_b[MJ[k]] * w_c[MI[k]];
            end
            for (int i = 0; i < 4; i++) begin
                r_a1[i] <= w_a[i];
            end
            // minors, signed first-row operands
            for (int k = 0; k < 6; k++) begin
                r_m[k] <= $signed({r_p1[k][2*VW-1], r_p1[k]})
                        - $signed({r_p2[k][2*VW-1], r_p2[k]});
            end
            for (int t = 0; t < 12; t++) begin
                r_ta[t] <= TN[t] ? -$signed({r_a1[TA[t]][VW-1], r_a1[TA[t]]})
                                 :  $signed({r_a1[TA[t]][VW-1], r_a1[TA[t]]});
            end
            // split each minor into low and high halves
            for (int t = 0; t < 12; t++) begin
                r_plo[t] <= r_ta[t] * $signed({1'b0, r_m[TM[t]][VW-1:0]});
                r_phi[t] <= r_ta[t] * $signed(r_m[TM[t]][MW-1:VW]);
            end
            for (int t = 0; t < 12; t++) begin
                r_t[t] <= ($signed({{(PW-2*VW-2){r_phi[t][2*VW+1]}}, r_phi[t]}) <<< VW)
                        + $signed({{(PW-2*VW-2){r_plo[t][2*VW+1]}}, r_plo[t]});
            end
            for (int s = 0; s < 4; s++) begin
                r_s[s] <= r_t[3*s] + r_t[3*s+1] + r_t[3*s+2];
            end
            // classify
            r_job.nx   <= r_s[1];
            r_job.ny   <= r_s[2];
            r_job.nz   <= r_s[3];
            r_job.dneg <= r_s[0][PW-1];
            r_job.dmag <= r_s[0][PW-1] ? $unsigned(-r_s[0]) : $unsigned(r_s[0]);
            r_job.sing <= (r_s[0] == '0) || ((r_s[0] < w_thr) && (r_s[0] > w_nthr));
        end
    end

endmodule

// ----- hdl/lss_queue.sv -----
// short queue between front and back pipelines
// depends on lss_pkg
module lss_queue #(
    parameter int DEPTH = lss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lss_pkg::t_job        i_job,
    input  logic                 i_pop,
    output lss_pkg::t_job        o_job,
    output lss_pkg::t_q_status   o_stat
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lss_pkg::t_job  r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_job  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/lss_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with saturation
// depends on lss_pkg
module lss_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [lss_pkg::PW-1:0] i_num,
    input  logic [lss_pkg::PW-1:0]        i_dmag,
    input  logic                          i_dneg,
    output logic signed [lss_pkg::VW-1:0] o_value,
    output logic                          o_sat
);
    localparam int VW = lss_pkg::VW;
    localparam int FB = lss_pkg::FB;
    localparam int PW = lss_pkg::PW;
    localparam int NW = lss_pkg::NW;
    localparam int RW = (NW - VW > PW) ? NW - VW : PW;

    logic [PW-1:0]   r_nmag;
    logic            r_neg0;
    logic [PW-1:0]   r_d0;
    logic [NW-1:0]   w_n2;
    logic [RW-1:0]   w_r0;
    logic [RW-1:0]   w_dx;

    // index 0 holds the initial remainder, index k the state after k steps
    logic [PW-1:0]   r_rem [VW+1];
    logic [VW-1:0]   r_q   [VW+1];
    logic [VW-1:0]   r_low [VW+1];
    logic [PW-1:0]   r_d   [VW+1];
    logic            r_ovf [VW+1];
    logic            r_neg [VW+1];

    logic [VW-1:0]   w_lim;
    logic [VW-1:0]   w_qf;

    assign w_n2 = {r_nmag, {FB{1'b0}}};
    assign w_r0 = RW'(w_n2[NW-1:VW]);
    assign w_dx = RW'(r_d0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nmag <= i_num[PW-1] ? $unsigned(-i_num) : $unsigned(i_num);
            r_neg0 <= i_num[PW-1] ^ i_dneg;
            r_d0   <= i_dmag;
            // a high part at or above the divisor means the quotient does not fit
            r_ovf[0] <= (w_r0 >= w_dx);
            r_rem[0] <= w_r0[PW-1:0];
            r_low[0] <= w_n2[VW-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= r_d0;
            r_neg[0] <= r_neg0;
        end
    end

    for (genvar k = 1; k <= VW; k++) begin : g_step
        logic [PW:0] w_try;
        logic [PW:0] w_diff;
        logic        w_ge;
        assign w_try  = {r_rem[k-1], r_low[k-1][VW-1]};
        assign w_ge   = (w_try >= {1'b0, r_d[k-1]});
        assign w_diff = w_try - {1'b0, r_d[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[PW-1:0] : w_try[PW-1:0];
                r_q[k]   <= {r_q[k-1][VW-2:0], w_ge};
                r_low[k] <= {r_low[k-1][VW-2:0], 1'b0};
                r_d[k]   <= r_d[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign w_qf  = r_q[VW];
    assign w_lim = {1'b1, {(VW-1){1'b0}}} - {{(VW-1){1'b0}}, !r_neg[VW]};
    assign o_sat = r_ovf[VW] || (w_qf > w_lim);

    always_comb begin
        if (o_sat) begin
            o_value = r_neg[VW] ? $signed({1'b1, {(VW-1){1'b0}}})
                                : $signed({1'b0, {(VW-1){1'b1}}});
        end else begin
            o_value = r_neg[VW] ? $signed(-w_qf) : $signed(w_qf);
        end
    end

endmodule

// ----- hdl/lss_back.sv -----
// back pipeline: three dividers in lockstep and the output register
// depends on lss_pkg, lss_div
module lss_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lss_pkg::t_job        i_job,
    input  logic                 i_job_valid,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lss_pkg::t_out_item   o_out_data
);
    localparam int VW  = lss_pkg::VW;
    localparam int LAT = VW + 2;

    logic                  w_en;
    logic [LAT-1:0]        r_bv;
    logic [LAT-1:0]        r_bs;
    logic signed [VW-1:0]  w_x;
    logic signed [VW-1:0]  w_y;
    logic signed [VW-1:0]  w_z;
    logic                  w_sx;
    logic                  w_sy;
    logic                  w_sz;
    logic                  r_ovalid;
    lss_pkg::t_out_item    r_out;

    assign w_en        = !r_ovalid || !i_out_stall;
    assign o_pop       = w_en && i_job_valid;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    lss_div u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(i_job.nx), .i_dmag(i_job.dmag),
        .i_dneg(i_job.dneg), .o_value(w_x), .o_sat(w_sx)
    );
    lss_div u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_num(i_job.ny), .i_dmag(i_job.dmag),
        .i_dneg(i_job.dneg), .o_value(w_y), .o_sat(w_sy)
    );
    lss_div u_div_z (
        .i_clk(i_clk), .i_en(w_en), .i_num(i_job.nz), .i_dmag(i_job.dmag),
        .i_dneg(i_job.dneg), .o_value(w_z), .o_sat(w_sz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv     <= '0;
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_bv     <= {r_bv[LAT-2:0], i_job_valid};
            r_ovalid <= r_bv[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bs <= {r_bs[LAT-2:0], i_job.sing};
            if (r_bs[LAT-1]) begin
                r_out.sol_x  <= '0;
                r_out.sol_y  <= '0;
                r_out.sol_z  <= '0;
                r_out.status <= lss_pkg::ST_SINGULAR;
            end else begin
                r_out.sol_x  <= w_x;
                r_out.sol_y  <= w_y;
                r_out.sol_z  <= w_z;
                r_out.status <= (w_sx || w_sy || w_sz) ? lss_pkg::ST_SATURATED
                                                       : lss_pkg::ST_SOLVED;
            end
        end
    end

endmodule

// ----- hdl/linear_system_3x3_solver_top.sv -----
// top level of the 3x3 linear system solver (cramer's rule, fixed point)
// depends on lss_pkg, lss_front, lss_queue, lss_back and the defines header
//
//  channel  direction  handshake                payload
//  in       input      i_in_valid / o_in_stall  i_in_data   (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg      input      i_cfg_we                 i_cfg_data  (det_threshold)
//
// one system accepted per cycle, one result per cycle sustained while i_out_stall and o_in_stall stay low
// path: 6 front stages, the queue, 34 divider stages (magnitude and remainder setup,
//   then one quotient bit per stage) and the output register
// reset is synchronous, active low; clears valids, queue pointers, threshold to 3
// an output stall freezes the back pipeline; the queue then fills and only then
//   does the front raise o_in_stall
`include "linear_system_3x3_solver_top_defines.svh"
module linear_system_3x3_solver_top #(
    parameter int QUEUE_DEPTH = lss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lss_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lss_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [lss_pkg::THR_W-1:0]  i_cfg_data
);

    // singular threshold, units of 2^-48 at the default format
    logic [lss_pkg::THR_W-1:0]  r_thr;
    // front to queue
    logic                       w_push;
    lss_pkg::t_job              w_fjob;
    // queue to back
    lss_pkg::t_job              w_qjob;
    lss_pkg::t_q_status         w_qstat;
    logic                       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= lss_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // multiply tree, cofactor sums and singular test
    lss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_thr      (r_thr),
        .i_q_full   (w_qstat.full),
        .o_push     (w_push),
        .o_job      (w_fjob)
    );

    // decouples the front stall from the output stall
    lss_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_qstat)
    );

    // three quotient pipelines and the result register
    lss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_qjob),
        .i_job_valid (!w_qstat.empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `LSS_ASSERT_IMPLY(a_push_room, w_push, !w_qstat.full, "item pushed into a full queue")
    `LSS_ASSERT_IMPLY(a_queue_flags, w_qstat.full, !w_qstat.empty, "queue full and empty")
    `LSS_ASSERT_IMPLY(a_sing_zero, o_out_valid && (o_out_data.status == lss_pkg::ST_SINGULAR), (o_out_data.sol_x == '0) && (o_out_data.sol_y == '0) && (o_out_data.sol_z == '0), "singular item with nonzero solution")
    `LSS_ASSERT_NEXT(a_pop_fills, w_pop && !i_out_stall && !o_out_valid, !w_qstat.full, "queue full right after a pop into an open back end")

endmodule

// ----- tb/tb_linear_system_3x3_solver_top.sv -----
// testbench for the 3x3 linear system solver top level
// depends on lss_pkg and linear_system_3x3_solver_top; exact cramer's-rule solution check
`timescale 1ns / 1ps
module tb_linear_system_3x3_solver_top;
    import lss_pkg::*;

    // drain wait after the last result: front, queue, divider and output register
    localparam int DRAIN_CYCLES = 80;
    // no acceptance for this many cycles ends the run; longest correct quiet
    // stretch is the long receiver hold plus pipeline latency
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [THR_W-1:0] i_cfg_data;

    // solutions still to come out, oldest first
    t_out_item   pending_solutions[$];
    logic [THR_W-1:0] singular_limit;
    int          error_count;
    int          idle_cycles;
    bit          sender_idles;
    bit          receiver_idles;
    bit          hold_request;

    linear_system_3x3_solver_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // one cramer quotient, truncated toward zero, saturated to the value range
    function automatic logic [VW-1:0] cramer_quotient(input logic signed [127:0] num,
                                                      input logic [127:0] dmag,
                                                      input bit dneg, inout bit sat);
        logic [127:0] nmag;
        logic [127:0] q;
        logic [127:0] lim;
        bit neg;
        neg  = (num < 0) ^ dneg;
        nmag = (num < 0) ? -num : num;
        q    = (nmag << FB) / dmag;
        lim  = neg ? (128'd1 << (VW - 1)) : ((128'd1 << (VW - 1)) - 1);
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? -q[VW-1:0] : q[VW-1:0];
    endfunction

    // exact determinant and cofactor sums in 128-bit signed arithmetic
    function automatic t_out_item solve_system(input t_in_item s);
        logic signed [127:0] a1, a2, a3, a0, b1, b2, b3, b0, c1, c2, c3, c0;
        logic signed [127:0] det, nx, ny, nz;
        logic [127:0] dmag;
        bit sat;
        t_out_item r;
        a1 = s.row1_coef_x; a2 = s.row1_coef_y; a3 = s.row1_coef_z; a0 = s.row1_offset;
        b1 = s.row2_coef_x; b2 = s.row2_coef_y; b3 = s.row2_coef_z; b0 = s.row2_offset;
        c1 = s.row3_coef_x; c2 = s.row3_coef_y; c3 = s.row3_coef_z; c0 = s.row3_offset;
        sat = 1'b0;
        det = a1*b2*c3 + a2*c1*b3 + a3*b1*c2 - a1*b3*c2 - a2*b1*c3 - a3*b2*c1;
        dmag = (det < 0) ? -det : det;
        if (dmag == 0 || dmag < {96'd0, singular_limit}) begin
            r = '{sol_x: '0, sol_y: '0, sol_z: '0, status: ST_SINGULAR};
            return r;
        end
        nx = a2*c3*b0 + a3*b2*c0 + a0*b3*c2 - a2*b3*c0 - a3*c2*b0 - a0*b2*c3;
        ny = a1*b3*c0 + a3*c1*b0 + a0*b1*c3 - a1*c3*b0 - a3*b1*c0 - a0*b3*c1;
        nz = a1*c2*b0 + a2*b1*c0 + a0*b2*c1 - a1*b2*c0 - a2*c1*b0 - a0*b1*c2;
        r.sol_x  = cramer_quotient(nx, dmag, det < 0, sat);
        r.sol_y  = cramer_quotient(ny, dmag, det < 0, sat);
        r.sol_z  = cramer_quotient(nz, dmag, det < 0, sat);
        r.status = sat ? ST_SATURATED : ST_SOLVED;
        return r;
    endfunction

    // offers one system, waits for acceptance, then maybe leaves a gap
    task automatic send_system(input t_in_item s);
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        pending_solutions.push_back(solve_system(s));
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // lower valid, wait for all solutions and the pipeline tail to clear
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_solutions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] thr);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        singular_limit = thr;
    endtask

    function automatic t_in_item make_system(input logic signed [VW-1:0] a1, a2, a3, a0,
                                             b1, b2, b3, b0, c1, c2, c3, c0);
        return '{a1, a2, a3, a0, b1, b2, b3, b0, c1, c2, c3, c0};
    endfunction

    function automatic logic [VW-1:0] rand_value(input int mode);
        case (mode)
            0:       return $urandom();
            1:       return $urandom_range(0, 8) - 4;                   // a few lsbs
            2:       return ($urandom_range(0, 20) - 10) <<< FB;         // small integers
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    // mixed systems: full range, tiny coefficients, integers and near-singular rows
    function automatic t_in_item random_system();
        t_in_item s;
        int mode;
        mode = $urandom_range(0, 9);
        s = make_system(rand_value(0), rand_value(0), rand_value(0), rand_value(0),
                        rand_value(0), rand_value(0), rand_value(0), rand_value(0),
                        rand_value(0), rand_value(0), rand_value(0), rand_value(0));
        if (mode inside {[4:6]}) begin
            // integer coefficients, offsets anywhere
            s.row1_coef_x = rand_value(2); s.row1_coef_y = rand_value(2);
            s.row1_coef_z = rand_value(2); s.row2_coef_x = rand_value(2);
            s.row2_coef_y = rand_value(2); s.row2_coef_z = rand_value(2);
            s.row3_coef_x = rand_value(2); s.row3_coef_y = rand_value(2);
            s.row3_coef_z = rand_value(2);
            if (mode == 6) s.row2_offset = rand_value(2);
        end else if (mode == 7) begin
            // tiny coefficients, determinant near the threshold, saturating quotients
            s.row1_coef_x = rand_value(1); s.row1_coef_y = rand_value(1);
            s.row1_coef_z = rand_value(1); s.row2_coef_x = rand_value(1);
            s.row2_coef_y = rand_value(1); s.row2_coef_z = rand_value(1);
            s.row3_coef_x = rand_value(1); s.row3_coef_y = rand_value(1);
            s.row3_coef_z = rand_value(1);
        end else if (mode == 8) begin
            // third row nearly a copy of the first
            s.row3_coef_x = s.row1_coef_x + rand_value(1);
            s.row3_coef_y = s.row1_coef_y + rand_value(1);
            s.row3_coef_z = s.row1_coef_z;
        end else if (mode == 9) begin
            s.row1_coef_x = rand_value(3); s.row2_coef_y = rand_value(3);
            s.row3_coef_z = rand_value(3); s.row1_offset = rand_value(3);
        end
        return s;
    endfunction

    // result checker against the oldest pending solution
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_solutions.size() == 0) begin
                $display("%0t: unexpected item %h", $time, o_out_data);
                error_count++;
            end else begin
                t_out_item want;
                want = pending_solutions.pop_front();
                if (o_out_data.sol_x !== want.sol_x) begin
                    $display("%0t: sol_x expected %h actual %h", $time, want.sol_x,
                             o_out_data.sol_x);
                    error_count++;
                end
                if (o_out_data.sol_y !== want.sol_y) begin
                    $display("%0t: sol_y expected %h actual %h", $time, want.sol_y,
                             o_out_data.sol_y);
                    error_count++;
                end
                if (o_out_data.sol_z !== want.sol_z) begin
                    $display("%0t: sol_z expected %h actual %h", $time, want.sol_z,
                             o_out_data.sol_z);
                    error_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_out_data.status);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stall bursts, or one long hold on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles with no accepted item on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("linear_system_3x3_solver_top verification failed");
            $finish;
        end
    end

    // corners: zero system, unit diagonal, range extremes, threshold edge
    task automatic test_directed();
        logic signed [VW-1:0] one, mx, mn;
        one = 32'sd1 <<< FB;
        mx  = 32'h7fff_ffff;
        mn  = 32'h8000_0000;
        send_system(make_system(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_system(make_system(one, 0, 0, -one, 0, one, 0, 5 * one, 0, 0, one, mn));
        send_system(make_system(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_system(make_system(mx, 0, 0, mn, 0, mx, 0, mx, 0, 0, mx, mn));
        send_system(make_system(mn, 0, 0, mx, 0, mn, 0, mn, 0, 0, mn, mx));
        send_system(make_system(mn, mx, 0, mn, mx, mn, 1, -1, 0, 1, mn, mx));
        // determinant one lsb: singular at reset threshold
        send_system(make_system(1, 0, 0, 7, 0, 1, 0, -7, 0, 0, 1, 0));
        // determinant exactly at and just below the threshold, offsets saturate
        send_system(make_system(3, 0, 0, mx, 0, 1, 0, mn, 0, 0, 1, 1));
        send_system(make_system(2, 0, 0, mx, 0, 1, 0, mn, 0, 0, 1, 1));
        send_system(make_system(-3, 0, 0, 1, 0, 1, 0, 0, 0, 0, 1, 0));
        send_system(make_system(one, 2 * one, 3 * one, one, 4 * one, 5 * one, 6 * one,
                                -one, 7 * one, 8 * one, 10 * one, 3 * one));
        send_system(make_system(-one, 0, 0, 1, 0, -one, 0, -1, 0, 0, one, -1));
        drain_block();
        // one lsb diagonal solves once the threshold is 1
        set_threshold(32'd1);
        send_system(make_system(1, 0, 0, 7, 0, 1, 0, -7, 0, 0, 1, 0));
        send_system(make_system(1, 0, 0, 0, 0, -1, 0, 0, 0, 0, 1, 0));
        send_system(make_system(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
        set_threshold(32'hffff_ffff);
        send_system(make_system(one, 0, 0, one, 0, one, 0, one, 0, 0, one, one));
        send_system(make_system(4, 0, 0, 1, 0, 32'h1000_0000, 0, 1, 0, 0, 32'sd4, 1));
        send_system(make_system(mx, 0, 0, one, 0, mx, 0, one, 0, 0, mx, one));
    endtask

    task automatic test_random(input int count);
        repeat (count) send_system(random_system());
    endtask

    // receiver holds for a long time while the sender keeps offering
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (60) send_system(random_system());
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        error_count    = 0;
        idle_cycles    = 0;
        hold_request   = 1'b0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        singular_limit = THR_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_threshold(32'd3);
        test_random(300);
        set_threshold(32'd1);
        test_random(250);
        set_threshold(32'h0001_0000);
        test_random(250);
        test_backpressure();
        set_threshold(32'hffff_ffff);
        test_random(200);
        set_threshold(32'd7);
        // streaming with no idling on either side
        drain_block();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random(300);
        drain_block();

        if (error_count == 0)
            $display("linear_system_3x3_solver_top verification clean");
        else
            $display("linear_system_3x3_solver_top verification failed");
        $finish;
    end

endmodule
